### src/alarm_table_matcher_macros.svh
// Assertion macros for the alarm table matcher checker
`ifndef ALARM_TABLE_MATCHER_MACROS_SVH
`define ALARM_TABLE_MATCHER_MACROS_SVH

// same-cycle implication, idle during reset
`define ATM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atm check failed");

// next-cycle implication, idle during reset
`define ATM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atm check failed");

// next-cycle implication, also checked across reset
`define ATM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("atm check failed");

`endif

### src/atm_pkg.sv
package atm_pkg;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_ADD        = 3'd1;
   localparam logic [2:0] CMD_ENABLE     = 3'd2;
   localparam logic [2:0] CMD_DISABLE    = 3'd3;
   localparam logic [2:0] CMD_RESET_MEMO = 3'd4;
   localparam logic [2:0] CMD_CLEAR      = 3'd5;

   localparam logic [1:0] KIND_FIRED = 2'd0;
   localparam logic [1:0] KIND_ADDED = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] ACT_EXT_NOPARAM = 2'd3;

   localparam logic [7:0] WILDCARD = 8'd255;
   localparam logic [6:0] ALL_DAYS = 7'h7F;
   localparam logic [2:0] LAST_WEEKDAY = 3'd6;

   typedef struct packed {
      logic        enabled;
      logic [6:0]  days;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [15:0] interval;
      logic [15:0] param;
      logic [1:0]  action;
   } setup_type;

   typedef struct packed {
      logic        valid;
      logic [8:0]  yday;
      logic [7:0]  minute;
      logic [7:0]  hour;
      logic [31:0] secs;
   } memo_type;

   typedef struct packed {
      logic setup_we;
      logic memo_we;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_EN_WR,
      ST_SWEEP,
      ST_RESP
   } state_type;

endpackage

### src/atm_store.sv
module atm_store #(
   parameter int NUM_ALARMS = 16,
   parameter int IW = 4
) (
   input  logic                 clock,
   input  atm_pkg::mem_ctl_type ctl,
   input  logic [IW-1:0]        setup_waddr,
   input  atm_pkg::setup_type   setup_wdata,
   input  logic [IW-1:0]        memo_waddr,
   input  atm_pkg::memo_type    memo_wdata,
   input  logic [IW-1:0]        rd_addr,
   output atm_pkg::setup_type   setup_rdata,
   output atm_pkg::memo_type    memo_rdata
);
   import atm_pkg::*;

   setup_type setup_mem [NUM_ALARMS];
   memo_type  memo_mem  [NUM_ALARMS];
   setup_type setup_rd_ff;
   memo_type  memo_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.setup_we) begin
         setup_mem[setup_waddr] <= setup_wdata;
      end
      setup_rd_ff <= setup_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.memo_we) begin
         memo_mem[memo_waddr] <= memo_wdata;
      end
      memo_rd_ff <= memo_mem[rd_addr];
   end

   assign setup_rdata = setup_rd_ff;
   assign memo_rdata  = memo_rd_ff;

endmodule

### src/atm_fire.sv
module atm_fire (
   input  atm_pkg::setup_type setup,
   input  atm_pkg::memo_type  memo,
   input  logic [7:0]         hour,
   input  logic [7:0]         minute,
   input  logic [2:0]         weekday,
   input  logic [8:0]         yday,
   input  logic [31:0]        now,
   output logic               fire
);
   import atm_pkg::*;

   logic [6:0]  today;
   logic        hok;
   logic        mok;
   logic [32:0] diff;
   logic [21:0] span;
   logic        elapsed;
   logic        same_slot;
   logic        match;

   always_comb begin
      today = (weekday <= LAST_WEEKDAY) ? (7'd1 << weekday) : 7'd0;
      hok   = (setup.hour == WILDCARD) || (setup.hour == hour);
      mok   = (setup.minute == WILDCARD) || (setup.minute == minute);
      diff  = {1'b0, now} - {1'b0, memo.secs};
      // minutes * 60 = minutes * 64 - minutes * 4
      span  = {setup.interval, 6'b0} - {4'b0, setup.interval, 2'b0};
      // backwards clock gives a negative difference
      elapsed = !diff[32] && (diff[31:0] >= {10'b0, span});
      same_slot = (memo.yday == yday) && (memo.minute == minute) &&
                  ((setup.hour != WILDCARD) || (memo.hour == hour));
      if (setup.interval != 16'd0) begin
         match = memo.valid ? elapsed : (hok && mok);
      end else begin
         match = hok && mok && (!memo.valid || !same_slot);
      end
      fire = setup.enabled && ((setup.days & today) != 7'd0) && match;
   end

endmodule

### src/alarm_table_matcher.sv
// Tick: the command is accepted, then the table entries are evaluated in
// order and the done result follows; a fire or the done result waits while
// the result register is full and stalled. Add and clear go straight to the
// response; enable and disable first pass through the enable write state.
// Reset memo: one memo entry rewritten per cycle through the single memo write port.
// One command at a time. Reset clears the state machine, the counters and the
// output valid flag; the alarm memories are not cleared.
module alarm_table_matcher #(
   parameter int NUM_ALARMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_hour,
   input  logic [7:0]  req_minute,
   input  logic [2:0]  req_weekday,
   input  logic [8:0]  req_year_day,
   input  logic [31:0] req_now_seconds,
   input  logic [6:0]  req_day_mask,
   input  logic [15:0] req_interval_min,
   input  logic [15:0] req_parameter_req,
   input  logic        req_enable_flag,
   input  logic [1:0]  req_action_kind,
   input  logic [3:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_fire_parameter,
   output logic [1:0]  rsp_fire_action,
   output logic [4:0]  rsp_fired_count,
   output logic        rsp_last
);
   import atm_pkg::*;

   localparam int IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int CW = $clog2(NUM_ALARMS + 1);
   localparam int FW = (CW > 5) ? CW : 5;

   state_type   state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [FW-1:0] fired_ff, fired_in;
   logic [7:0]  t_hour_ff, t_hour_in;
   logic [7:0]  t_minute_ff, t_minute_in;
   logic [2:0]  t_weekday_ff, t_weekday_in;
   logic [8:0]  t_yday_ff, t_yday_in;
   logic [31:0] t_now_ff, t_now_in;
   logic        en_val_ff, en_val_in;
   logic        en_hit_ff, en_hit_in;
   logic [1:0]  res_kind_ff, res_kind_in;
   logic [3:0]  res_slot_ff, res_slot_in;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [3:0]  rsp_slot_ff;
   logic [15:0] rsp_param_ff;
   logic [1:0]  rsp_action_ff;
   logic [4:0]  rsp_count_ff;
   logic        rsp_last_ff;

   logic        emit;
   logic [1:0]  e_kind;
   logic [3:0]  e_slot;
   logic [15:0] e_param;
   logic [1:0]  e_action;
   logic [4:0]  e_count;
   logic        e_last;
   logic        out_free;

   mem_ctl_type ctl;
   logic [IW-1:0] setup_waddr, memo_waddr, rd_addr;
   setup_type   setup_wdata, setup_rdata;
   memo_type    memo_wdata, memo_rdata;
   logic        fire;
   logic [7:0]  count_wide;
   logic [7:0]  idx_wide;

   atm_store #(.NUM_ALARMS(NUM_ALARMS), .IW(IW)) u_store (
      .clock       (clock),
      .ctl         (ctl),
      .setup_waddr (setup_waddr),
      .setup_wdata (setup_wdata),
      .memo_waddr  (memo_waddr),
      .memo_wdata  (memo_wdata),
      .rd_addr     (rd_addr),
      .setup_rdata (setup_rdata),
      .memo_rdata  (memo_rdata)
   );

   atm_fire u_fire (
      .setup   (setup_rdata),
      .memo    (memo_rdata),
      .hour    (t_hour_ff),
      .minute  (t_minute_ff),
      .weekday (t_weekday_ff),
      .yday    (t_yday_ff),
      .now     (t_now_ff),
      .fire    (fire)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign count_wide = 8'(count_ff);
   assign idx_wide   = 8'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      fired_in     = fired_ff;
      t_hour_in    = t_hour_ff;
      t_minute_in  = t_minute_ff;
      t_weekday_in = t_weekday_ff;
      t_yday_in    = t_yday_ff;
      t_now_in     = t_now_ff;
      en_val_in    = en_val_ff;
      en_hit_in    = en_hit_ff;
      res_kind_in  = res_kind_ff;
      res_slot_in  = res_slot_ff;
      ctl          = '0;
      setup_waddr  = idx_ff[IW-1:0];
      memo_waddr   = idx_ff[IW-1:0];
      setup_wdata  = setup_rdata;
      memo_wdata   = '0;
      emit         = 1'b0;
      e_kind       = KIND_DONE;
      e_slot       = 4'd0;
      e_param      = 16'd0;
      e_action     = 2'd0;
      e_count      = 5'd0;
      e_last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               res_kind_in = KIND_DONE;
               res_slot_in = 4'd0;
               state_in    = ST_RESP;
               unique case (req_command)
                  CMD_TICK: begin
                     t_hour_in    = req_hour;
                     t_minute_in  = req_minute;
                     t_weekday_in = req_weekday;
                     t_yday_in    = req_year_day;
                     t_now_in     = req_now_seconds;
                     fired_in     = '0;
                     state_in     = ST_TICK;
                  end
                  CMD_ADD: begin
                     if (count_ff >= CW'(NUM_ALARMS)) begin
                        res_kind_in = KIND_FULL;
                     end else begin
                        ctl.setup_we         = 1'b1;
                        ctl.memo_we          = 1'b1;
                        setup_waddr          = count_ff[IW-1:0];
                        memo_waddr           = count_ff[IW-1:0];
                        setup_wdata.enabled  = req_enable_flag;
                        setup_wdata.days     = (req_day_mask != 7'd0) ? req_day_mask
                                                                      : ALL_DAYS;
                        setup_wdata.hour     = req_hour;
                        setup_wdata.minute   = req_minute;
                        setup_wdata.interval = req_interval_min;
                        setup_wdata.action   = req_action_kind;
                        setup_wdata.param    = (req_action_kind == ACT_EXT_NOPARAM)
                                               ? 16'd0 : req_parameter_req;
                        res_kind_in          = KIND_ADDED;
                        res_slot_in          = count_wide[3:0];
                        count_in             = count_ff + 1'b1;
                     end
                  end
                  CMD_ENABLE, CMD_DISABLE: begin
                     idx_in    = CW'(req_entry_index);
                     en_val_in = (req_command == CMD_ENABLE);
                     en_hit_in = ({3'b0, req_entry_index} < 7'(count_ff));
                     state_in  = ST_EN_WR;
                  end
                  CMD_RESET_MEMO: begin
                     state_in = ST_SWEEP;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (idx_ff == count_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_count  = fired_ff[4:0];
                  state_in = ST_IDLE;
               end
            end else if (!fire) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               emit              = 1'b1;
               e_kind            = KIND_FIRED;
               e_slot            = idx_wide[3:0];
               e_param           = setup_rdata.param;
               e_action          = setup_rdata.action;
               e_last            = 1'b0;
               ctl.memo_we       = 1'b1;
               memo_wdata.valid  = 1'b1;
               memo_wdata.yday   = t_yday_ff;
               memo_wdata.minute = t_minute_ff;
               memo_wdata.hour   = t_hour_ff;
               memo_wdata.secs   = t_now_ff;
               fired_in          = fired_ff + 1'b1;
               idx_in            = idx_ff + 1'b1;
            end
         end
         ST_EN_WR: begin
            ctl.setup_we        = en_hit_ff;
            setup_wdata.enabled = en_val_ff;
            state_in            = ST_RESP;
         end
         ST_SWEEP: begin
            ctl.memo_we = 1'b1;
            if (idx_ff == CW'(NUM_ALARMS - 1)) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = res_kind_ff;
               e_slot   = res_slot_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next entry is read while the current one is evaluated
      rd_addr = idx_in[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         fired_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         fired_ff <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      t_hour_ff    <= t_hour_in;
      t_minute_ff  <= t_minute_in;
      t_weekday_ff <= t_weekday_in;
      t_yday_ff    <= t_yday_in;
      t_now_ff     <= t_now_in;
      en_val_ff    <= en_val_in;
      en_hit_ff    <= en_hit_in;
      res_kind_ff  <= res_kind_in;
      res_slot_ff  <= res_slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_kind_ff   <= e_kind;
         rsp_slot_ff   <= e_slot;
         rsp_param_ff  <= e_param;
         rsp_action_ff <= e_action;
         rsp_count_ff  <= e_count;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_fire_parameter = rsp_param_ff;
   assign rsp_fire_action    = rsp_action_ff;
   assign rsp_fired_count    = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

### src/atm_checker.sv
`include "alarm_table_matcher_macros.svh"

module atm_checker #(
   parameter int NUM_ALARMS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_slot,
   input logic [15:0] rsp_fire_parameter,
   input logic [4:0]  rsp_fired_count,
   input logic        rsp_last
);
   import atm_pkg::*;

   logic [6:0] fired_limit;
   assign fired_limit = 7'(NUM_ALARMS);

   `ATM_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
   `ATM_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ATM_ASSERT_IMPL(a_fired_not_last, clock, reset, rsp_valid && (rsp_kind == KIND_FIRED), !rsp_last)
   `ATM_ASSERT_IMPL(a_done_clean, clock, reset, rsp_valid && (rsp_kind == KIND_DONE), rsp_last && (rsp_slot == 4'd0) && (rsp_fire_parameter == 16'd0) && ({2'b0, rsp_fired_count} <= fired_limit))
   `ATM_ASSERT_IMPL(a_busy_while_fired, clock, reset, rsp_valid && (rsp_kind == KIND_FIRED), req_stall)

endmodule

bind alarm_table_matcher atm_checker #(.NUM_ALARMS(NUM_ALARMS)) u_atm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_slot           (rsp_slot),
   .rsp_fire_parameter (rsp_fire_parameter),
   .rsp_fired_count    (rsp_fired_count),
   .rsp_last           (rsp_last)
);
